// ===== rtl/core/mu7_pkg.sv =====
// Shared types, constants and helper functions for the modified UTF-7 decoder.
package mu7_pkg;

    localparam int unsigned MU7_QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_DASH = 8'h2d;

    typedef enum logic [1:0] {
        MODE_DIRECT = 2'd0,
        MODE_AMP    = 2'd1,
        MODE_RUN    = 2'd2,
        MODE_SKIP   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        DIG_VAL  = 2'd0,
        DIG_WS   = 2'd1,
        DIG_BAD  = 2'd2
    } dig_kind_t;

    typedef struct packed {
        dig_kind_t  kind;
        logic [5:0] value;
    } dig_t;

    // One queued command: up to three result words from one input word
    typedef struct packed {
        logic [1:0]      last_idx;
        logic [2:0][7:0] bytes;
        logic            byte_valid;
        logic            error;
        logic            last;
    } cmd_t;

    function automatic dig_t digit_of(input logic [7:0] c);
        dig_t d;
        d.kind  = DIG_VAL;
        d.value = 6'd0;
        if (c inside {[8'h41:8'h5a]}) begin
            d.value = 6'(c - 8'h41);
        end
        else if (c inside {[8'h61:8'h7a]}) begin
            d.value = 6'(c - 8'h61 + 8'd26);
        end
        else if (c inside {[8'h30:8'h39]}) begin
            d.value = 6'(c - 8'h30 + 8'd52);
        end
        else if (c == 8'h2b) begin
            d.value = 6'd62;
        end
        else if (c == 8'h2c) begin
            d.value = 6'd63;
        end
        else if (c inside {8'h09, 8'h0a, 8'h0d, 8'h20}) begin
            d.kind = DIG_WS;
        end
        else begin
            d.kind = DIG_BAD;
        end
        return d;
    endfunction

endpackage

// ===== rtl/core/mu7_front.sv =====
// Front end: takes input words, tracks run state and builds result commands.
module mu7_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    char_code,
    input  logic          last,
    input  logic          full,
    output logic          push,
    output mu7_pkg::cmd_t push_cmd
);
    import mu7_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [14:0] acc_reg, acc_next;
    logic [3:0]  cnt_reg, cnt_next;

    dig_t        dig;
    logic [20:0] v;
    logic [4:0]  cnt6;
    logic        emit;
    logic [3:0]  nc;
    logic [15:0] unit;
    logic [20:0] keep_mask;
    logic        accept;

    assign in_ready = !full;
    assign accept   = in_valid && !full;

    assign dig       = digit_of(char_code);
    assign v         = {acc_reg, dig.value};
    assign cnt6      = {1'b0, cnt_reg} + 5'd6;
    assign emit      = cnt6 >= 5'd16;
    assign nc        = cnt6[3:0];
    assign unit      = 16'(v >> nc);
    assign keep_mask = (21'd1 << nc) - 21'd1;

    always_comb
    begin
        logic [2:0] nres;
        logic       run;
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        nres      = 3'd0;
        run       = 1'b0;
        push_cmd  = '0;
        push_cmd.byte_valid = 1'b1;
        case (mode_reg)
            MODE_DIRECT:
            begin
                if (char_code == CH_AMP && !last) begin
                    mode_next = MODE_AMP;
                    acc_next  = '0;
                    cnt_next  = '0;
                end
                else begin
                    push_cmd.bytes[0] = char_code;
                    nres = 3'd1;
                end
            end
            MODE_AMP:
            begin
                if (char_code == CH_DASH) begin
                    push_cmd.bytes[0] = CH_AMP;
                    nres = 3'd1;
                    mode_next = MODE_DIRECT;
                end
                else begin
                    mode_next = MODE_RUN;
                    run = 1'b1;
                end
            end
            MODE_RUN:
            begin
                if (char_code == CH_DASH) begin
                    mode_next = MODE_DIRECT;
                    acc_next  = '0;
                    cnt_next  = '0;
                end
                else begin
                    run = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        if (run) begin
            case (dig.kind)
                DIG_BAD:
                begin
                    push_cmd.byte_valid = 1'b0;
                    push_cmd.error      = 1'b1;
                    nres      = 3'd1;
                    mode_next = MODE_SKIP;
                    acc_next  = '0;
                    cnt_next  = '0;
                end
                DIG_VAL:
                begin
                    if (emit) begin
                        cnt_next = nc;
                        acc_next = 15'(v & keep_mask);
                        if (unit <= 16'h007f) begin
                            push_cmd.bytes[0] = unit[7:0];
                            nres = 3'd1;
                        end
                        else if (unit <= 16'h07ff) begin
                            push_cmd.bytes[0] = 8'hc0 | {3'd0, unit[10:6]};
                            push_cmd.bytes[1] = 8'h80 | {2'd0, unit[5:0]};
                            nres = 3'd2;
                        end
                        else begin
                            push_cmd.bytes[0] = 8'he0 | {4'd0, unit[15:12]};
                            push_cmd.bytes[1] = 8'h80 | {2'd0, unit[11:6]};
                            push_cmd.bytes[2] = 8'h80 | {2'd0, unit[5:0]};
                            nres = 3'd3;
                        end
                    end
                    else begin
                        cnt_next = nc;
                        acc_next = v[14:0];
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (last) begin
            if (nres == 3'd0) begin
                push_cmd.byte_valid = 1'b0;
                push_cmd.error      = 1'b0;
                nres = 3'd1;
            end
            mode_next = MODE_DIRECT;
            acc_next  = '0;
            cnt_next  = '0;
        end

        push_cmd.last     = last;
        push_cmd.last_idx = 2'(nres - 3'd1);
        push = accept && (nres != 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_DIRECT;
            acc_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (accept) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/mu7_queue.sv =====
// Short command queue between the front and back ends.
module mu7_queue
#(
    parameter int unsigned DEPTH = mu7_pkg::MU7_QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mu7_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output mu7_pkg::cmd_t head_cmd
);
    import mu7_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full       = count_reg == CW'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/mu7_back.sv =====
// Back end: unpacks queued commands into result words behind an output register.
module mu7_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  mu7_pkg::cmd_t head_cmd,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic [2:0]    out_flags,
    output logic          out_end
);
    import mu7_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;
    logic [2:0] flags_reg;
    logic       end_reg;
    logic       load;
    logic       final_word;

    assign load       = head_valid && (!valid_reg || out_ready);
    assign final_word = idx_reg == head_cmd.last_idx;
    assign pop        = load && final_word;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            idx_next   = final_word ? 2'd0 : idx_reg + 2'd1;
            valid_next = 1'b1;
        end
        else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            byte_reg  <= head_cmd.byte_valid ? head_cmd.bytes[idx_reg] : 8'd0;
            flags_reg <= {final_word, head_cmd.error, head_cmd.byte_valid};
            end_reg   <= final_word && head_cmd.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_flags = flags_reg;
    assign out_end   = end_reg;

endmodule

// ===== rtl/core/modified_utf7_to_utf8_decoder.sv =====
// Top level of the modified UTF-7 (IMAP folder name) to UTF-8 decoder.
//
// Input stream: one encoded byte per word on s_axis_tdata, s_axis_tlast marks
// the final byte of a name. Output stream: one result word per transfer, the
// UTF-8 byte on m_axis_tdata, flags on m_axis_tuser, m_axis_tlast on the final
// result of the name.
// An input word gives up to three result words; a run byte that completes
// no code unit, whitespace, an opening '&' and a run-closing '-' give none
// unless it is the last byte, which always yields at least a marker word.
// A result passes through the command queue and then the output register.
// Throughput: one input word per cycle into the front end while the queue is
// not full, one result word per cycle out of the back end while the receiver
// is ready; the back end sends the bytes of a command one by one, and the
// command queue (QUEUE_DEPTH entries) absorbs the difference.
// Reset clears run state, the queue and the output valid flag.
// When the receiver stalls, the output register holds its word, the queue
// fills and s_axis_tready drops once the queue is full.
module modified_utf7_to_utf8_decoder
#(
    parameter int unsigned QUEUE_DEPTH = mu7_pkg::MU7_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [2:0] m_axis_tuser,   // [0] byte_valid, [1] error, [2] run_last
    output logic       m_axis_tlast
);
    import mu7_pkg::*;

    logic full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    mu7_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .char_code (s_axis_tdata),
        .last      (s_axis_tlast),
        .full      (full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    mu7_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    mu7_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .out_flags  (m_axis_tuser),
        .out_end    (m_axis_tlast)
    );

endmodule

// ===== verif/modified_utf7_to_utf8_decoder_tb.sv =====
// Self-checking testbench for the modified UTF-7 to UTF-8 decoder.
`timescale 1ns / 1ps

module modified_utf7_to_utf8_decoder_tb;

    import mu7_pkg::*;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_WORDS = 350;
    localparam int          CLS_WS       = 64;
    localparam int          CLS_BAD      = 65;
    localparam int          HOLD_START   = 300;
    localparam int          HOLD_LEN     = 80;
    localparam int          RX_CALM_LO   = 600;
    localparam int          RX_CALM_HI   = 900;
    localparam int          TX_CALM_LO   = 200;
    localparam int          TX_CALM_HI   = 300;
    localparam int          N_DIR        = 26;
    // tuser values for single-word results: {run_last, error, byte_valid}
    localparam logic [2:0]  USR_BYTE     = 3'b101;
    localparam logic [2:0]  USR_ERROR    = 3'b110;
    localparam logic [2:0]  USR_MARKER   = 3'b100;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       error;
        logic       run_last;
        logic       stream_end;
    } utf8_word_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       lst;
        logic       typed;
        logic [7:0] ex_data;
        logic [2:0] ex_user;
        logic       ex_end;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic       m_axis_tlast;

    utf8_word_t utf8_q[$];
    utf8_word_t step_res[$];
    stim_row_t  dir_tab [N_DIR];

    mode_t       dec_mode = MODE_DIRECT;
    logic [14:0] dec_acc = 15'd0;
    logic [3:0]  dec_cnt = 4'd0;

    int cyc = 0;
    int rx_cyc = 0;
    int n_in = 0;
    int n_out = 0;
    int n_names = 0;
    int n_err = 0;
    int fail_cnt = 0;

    modified_utf7_to_utf8_decoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    function automatic int b64_value(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return int'(c - "A");
        if (c >= "a" && c <= "z") return int'(c - "a") + 26;
        if (c >= "0" && c <= "9") return int'(c - "0") + 52;
        if (c == "+") return 62;
        if (c == ",") return 63;
        if (c == 8'h09 || c == 8'h0a || c == 8'h0d || c == 8'h20) return CLS_WS;
        return CLS_BAD;
    endfunction

    function automatic logic [7:0] b64_char(input int d);
        if (d < 26) return 8'("A" + d);
        if (d < 52) return 8'("a" + d - 26);
        if (d < 62) return 8'("0" + d - 52);
        if (d == 62) return "+";
        return ",";
    endfunction

    function automatic void push_res(input logic [7:0] b, input logic v, input logic e);
        utf8_word_t w;
        w = '{out_byte: b, byte_valid: v, error: e, run_last: 1'b0, stream_end: 1'b0};
        step_res = {step_res, w};
    endfunction

    function automatic void run_digit(input logic [7:0] c);
        int          d;
        int          v;
        int          n;
        logic [15:0] u;
        d = b64_value(c);
        if (d == CLS_BAD)
        begin
            push_res(8'h00, 1'b0, 1'b1);
            dec_mode = MODE_SKIP;
            dec_acc  = 15'd0;
            dec_cnt  = 4'd0;
        end
        else if (d != CLS_WS)
        begin
            v = (int'(dec_acc) << 6) | d;
            n = int'(dec_cnt) + 6;
            if (n >= 16)
            begin
                n = n - 16;
                u = 16'(v >> n);
                if (u <= 16'h007f)
                begin
                    push_res(u[7:0], 1'b1, 1'b0);
                end
                else if (u <= 16'h07ff)
                begin
                    push_res(8'hc0 | {3'b000, u[10:6]}, 1'b1, 1'b0);
                    push_res(8'h80 | {2'b00, u[5:0]}, 1'b1, 1'b0);
                end
                else
                begin
                    push_res(8'he0 | {4'b0000, u[15:12]}, 1'b1, 1'b0);
                    push_res(8'h80 | {2'b00, u[11:6]}, 1'b1, 1'b0);
                    push_res(8'h80 | {2'b00, u[5:0]}, 1'b1, 1'b0);
                end
                v = v & ((1 << n) - 1);
            end
            dec_acc = 15'(v);
            dec_cnt = 4'(n);
        end
    endfunction

    // Expected UTF-8 words for one accepted input byte, left in step_res
    function automatic void decode_byte(input logic [7:0] c, input logic lst);
        step_res.delete();
        case (dec_mode)
            MODE_DIRECT:
            begin
                if (c == CH_AMP)
                begin
                    if (lst)
                    begin
                        push_res(CH_AMP, 1'b1, 1'b0);
                    end
                    else
                    begin
                        dec_mode = MODE_AMP;
                        dec_acc  = 15'd0;
                        dec_cnt  = 4'd0;
                    end
                end
                else
                begin
                    push_res(c, 1'b1, 1'b0);
                end
            end
            MODE_AMP:
            begin
                if (c == CH_DASH)
                begin
                    push_res(CH_AMP, 1'b1, 1'b0);
                    dec_mode = MODE_DIRECT;
                end
                else
                begin
                    dec_mode = MODE_RUN;
                    run_digit(c);
                end
            end
            MODE_RUN:
            begin
                if (c == CH_DASH)
                begin
                    dec_mode = MODE_DIRECT;
                    dec_acc  = 15'd0;
                    dec_cnt  = 4'd0;
                end
                else
                begin
                    run_digit(c);
                end
            end
            default:
            begin
            end
        endcase
        if (lst && step_res.size() == 0) push_res(8'h00, 1'b0, 1'b0);
        if (step_res.size() > 0)
        begin
            step_res[step_res.size() - 1].run_last   = 1'b1;
            step_res[step_res.size() - 1].stream_end = lst;
        end
        if (lst)
        begin
            dec_mode = MODE_DIRECT;
            dec_acc  = 15'd0;
            dec_cnt  = 4'd0;
        end
    endfunction

    task automatic send_word(input logic [7:0] c, input logic lst, input logic typed,
                             input logic [7:0] ex_data, input logic [2:0] ex_user,
                             input logic ex_end);
        int         gap;
        utf8_word_t w;
        gap = 0;
        if (!(n_in >= N_DIR + TX_CALM_LO && n_in < N_DIR + TX_CALM_HI) &&
            $urandom_range(0, 99) < 15)
        begin
            gap = 1;
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= lst;
        do @(posedge clk); while (!s_axis_tready);
        decode_byte(c, lst);
        if (typed)
        begin
            step_res.delete();
            w = '{out_byte: ex_data, byte_valid: ex_user[0], error: ex_user[1],
                  run_last: ex_user[2], stream_end: ex_end};
            step_res = {step_res, w};
        end
        foreach (step_res[i]) utf8_q = {utf8_q, step_res[i]};
        n_in = n_in + 1;
        if (lst) n_names = n_names + 1;
    endtask

    // Mostly well-formed names with random content; some broken runs and raw noise
    task automatic send_random_name();
        logic [7:0] nm[$];
        int         kind;
        int         segs;
        int         t;
        int         c;
        kind = $urandom_range(0, 99);
        if (kind < 80)
        begin
            segs = $urandom_range(1, 3);
            for (int s = 0; s < segs; s++)
            begin
                t = $urandom_range(0, 9);
                if (t < 4)
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        c = ($urandom_range(0, 9) < 7) ? $urandom_range(8'h20, 8'h7e)
                                                       : $urandom_range(0, 255);
                        if (c == CH_AMP) c = "%";
                        nm = {nm, 8'(c)};
                    end
                end
                else if (t == 4)
                begin
                    nm = {nm, CH_AMP};
                    nm = {nm, CH_DASH};
                end
                else
                begin
                    nm = {nm, CH_AMP};
                    repeat ($urandom_range(1, 9))
                    begin
                        if ($urandom_range(0, 99) < 10)
                        begin
                            case ($urandom_range(0, 3))
                                0:       nm = {nm, 8'h09};
                                1:       nm = {nm, 8'h0a};
                                2:       nm = {nm, 8'h0d};
                                default: nm = {nm, 8'h20};
                            endcase
                        end
                        else
                        begin
                            nm = {nm, b64_char(($urandom_range(0, 9) < 4) ? 0
                                               : $urandom_range(0, 63))};
                        end
                    end
                    if (s != segs - 1 || $urandom_range(0, 2) != 0) nm = {nm, CH_DASH};
                end
            end
        end
        else if (kind < 92)
        begin
            nm = {nm, CH_AMP};
            repeat ($urandom_range(0, 5)) nm = {nm, b64_char($urandom_range(0, 63))};
            case ($urandom_range(0, 3))
                0:       nm = {nm, 8'h3d};
                1:       nm = {nm, 8'h2f};
                2:       nm = {nm, CH_AMP};
                default: nm = {nm, 8'($urandom_range(8'h80, 8'hff))};
            endcase
            repeat ($urandom_range(0, 4)) nm = {nm, 8'($urandom_range(0, 255))};
        end
        else
        begin
            repeat ($urandom_range(1, 8))
            begin
                nm = {nm, (($urandom_range(0, 3) == 0) ? CH_AMP
                                                        : 8'($urandom_range(0, 255)))};
            end
        end
        foreach (nm[i]) send_word(nm[i], i == nm.size() - 1, 1'b0, 8'h00, 3'b000, 1'b0);
    endtask

    function automatic void check_field(input string fname, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, act_v);
            fail_cnt = fail_cnt + 1;
        end
    endfunction

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected", cyc, utf8_q.size());
            $display("modified_utf7_to_utf8_decoder_tb: errors");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off, one calm stretch
    always @(posedge clk)
    begin
        rx_cyc <= rx_cyc + 1;
        if (rx_cyc >= HOLD_START && rx_cyc < HOLD_START + HOLD_LEN)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (rx_cyc >= RX_CALM_LO && rx_cyc < RX_CALM_HI)
        begin
            m_axis_tready <= 1'b1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= 15);
        end
    end

    always @(posedge clk)
    begin
        utf8_word_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_out = n_out + 1;
            if (m_axis_tuser[1]) n_err = n_err + 1;
            if (utf8_q.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %h/%b/%b", $time,
                         m_axis_tdata, m_axis_tuser, m_axis_tlast);
                fail_cnt = fail_cnt + 1;
            end
            else
            begin
                w = utf8_q.pop_front();
                check_field("out_byte", w.out_byte, m_axis_tdata);
                check_field("byte_valid", w.byte_valid, m_axis_tuser[0]);
                check_field("error", w.error, m_axis_tuser[1]);
                check_field("run_last", w.run_last, m_axis_tuser[2]);
                check_field("stream_end", w.stream_end, m_axis_tlast);
            end
        end
    end

    initial
    begin
        dir_tab = '{
            '{"A",     1'b0, 1'b1, "A",    USR_BYTE,   1'b0},
            '{8'h00,   1'b0, 1'b1, 8'h00,  USR_BYTE,   1'b0},
            '{8'hff,   1'b0, 1'b1, 8'hff,  USR_BYTE,   1'b0},
            '{CH_AMP,  1'b0, 1'b0, 8'h00,  3'b000,     1'b0},
            '{CH_DASH, 1'b0, 1'b1, CH_AMP, USR_BYTE,   1'b0},
            '{CH_AMP,  1'b0, 1'b0, 8'h00,  3'b000,     1'b0},
            '{"A",     1'b0, 1'b0, 8'h00,  3'b000,     1'b0},
            '{"O",     1'b0, 1'b0, 8'h00,  3'b000,     1'b0},
            '{"k",     1'b0, 1'b0, 8'h00,  3'b000,     1'b0},
            '{CH_DASH, 1'b0, 1'b0, 8'h00,  3'b000,     1'b0},
            '{CH_AMP,  1'b0, 1'b0, 8'h00,  3'b000,     1'b0},
            '{8'h20,   1'b0, 1'b0, 8'h00,  3'b000,     1'b0},
            '{"Z",     1'b0, 1'b0, 8'h00,  3'b000,     1'b0},
            '{"e",     1'b0, 1'b0, 8'h00,  3'b000,     1'b0},
            '{8'h09,   1'b0, 1'b0, 8'h00,  3'b000,     1'b0},
            '{"V",     1'b0, 1'b0, 8'h00,  3'b000,     1'b0},
            '{"n",     1'b0, 1'b0, 8'h00,  3'b000,     1'b0},
            '{8'h0a,   1'b0, 1'b0, 8'h00,  3'b000,     1'b0},
            '{"L",     1'b0, 1'b0, 8'h00,  3'b000,     1'b0},
            '{"I",     1'b0, 1'b0, 8'h00,  3'b000,     1'b0},
            '{8'h80,   1'b0, 1'b1, 8'h00,  USR_ERROR,  1'b0},
            '{"x",     1'b1, 1'b1, 8'h00,  USR_MARKER, 1'b1},
            '{CH_AMP,  1'b1, 1'b1, CH_AMP, USR_BYTE,   1'b1},
            '{CH_AMP,  1'b0, 1'b0, 8'h00,  3'b000,     1'b0},
            '{",",     1'b0, 1'b0, 8'h00,  3'b000,     1'b0},
            '{"=",     1'b1, 1'b1, 8'h00,  USR_ERROR,  1'b1}
        };
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < N_DIR; i++)
        begin
            send_word(dir_tab[i].ch, dir_tab[i].lst, dir_tab[i].typed,
                      dir_tab[i].ex_data, dir_tab[i].ex_user, dir_tab[i].ex_end);
        end
        while (n_in < N_DIR + RANDOM_WORDS) send_random_name();
        s_axis_tvalid <= 1'b0;
        while (utf8_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("covered %0d names, %0d input words, %0d UTF-8 words out (%0d error markers)",
                 n_names, n_in, n_out, n_err);
        $display("with random stalls on both sides and a %0d-cycle receiver hold-off",
                 HOLD_LEN);
        if (fail_cnt == 0 && utf8_q.size() == 0)
        begin
            $display("modified_utf7_to_utf8_decoder_tb: clean");
        end
        else
        begin
            $display("modified_utf7_to_utf8_decoder_tb: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/mu7_pkg.sv
rtl/core/mu7_front.sv
rtl/core/mu7_queue.sv
rtl/core/mu7_back.sv
rtl/core/modified_utf7_to_utf8_decoder.sv
verif/modified_utf7_to_utf8_decoder_tb.sv
